@@ sv/mieafr_pkg.sv @@
// Shared types, constants and saturation helper for the Mie angular function core.
package mieafr_pkg;

   localparam int MAX_ORDERS_DEFAULT = 64;

   localparam int RESULT_W    = 48;
   localparam int COS_W       = 18;
   localparam int ORDER_NUM_W = 7;
   localparam int FRAC_W      = 16;
   localparam int RECIP_W     = 32;
   localparam int SAT_IN_W    = 64;

   localparam logic [ORDER_NUM_W-1:0] ORDER_COUNT_RESET = 7'd64;
   localparam logic [ORDER_NUM_W-1:0] ORDER_COUNT_MIN   = 7'd2;

   typedef logic signed [RESULT_W-1:0] result_type;
   typedef logic signed [COS_W-1:0]    cos_type;
   typedef logic [ORDER_NUM_W-1:0]     order_num_type;

   localparam result_type ONE_Q16    = 48'sd65536;
   localparam result_type RESULT_MAX = {1'b0, {(RESULT_W-1){1'b1}}};
   localparam result_type RESULT_MIN = {1'b1, {(RESULT_W-1){1'b0}}};

   typedef struct packed {
      logic load;
      logic square;
      logic mul_a;
      logic round;
      logic scale_a;
      logic numer;
      logic div_lo;
      logic div_hi;
      logic quo_sat;
      logic mul_b;
      logic scale_b;
      logic tau;
      logic emit;
      logic last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   function automatic result_type sat_result(input logic signed [SAT_IN_W-1:0] x);
      logic signed [SAT_IN_W-1:0] hi_lim;
      logic signed [SAT_IN_W-1:0] lo_lim;
      result_type                 res;
      hi_lim = SAT_IN_W'(RESULT_MAX);
      lo_lim = SAT_IN_W'(RESULT_MIN);
      priority if (x > hi_lim) begin
         res = RESULT_MAX;
      end else if (x < lo_lim) begin
         res = RESULT_MIN;
      end else begin
         res = RESULT_W'(x);
      end
      return res;
   endfunction

endpackage

@@ sv/mieafr_if.sv @@
// Valid/ready channel interfaces for cosine input, result output and register write.
interface mieafr_req_if import mieafr_pkg::*; ();
   logic    valid;
   logic    ready;
   cos_type cos_angle;

   modport source (output valid, output cos_angle, input ready);
   modport sink   (input valid, input cos_angle, output ready);
endinterface

interface mieafr_rsp_if import mieafr_pkg::*; ();
   logic          valid;
   logic          ready;
   result_type    pi_value;
   result_type    tau_value;
   order_num_type order_number;
   logic          last_order;

   modport source (output valid, output pi_value, output tau_value, output order_number,
                   output last_order, input ready);
   modport sink   (input valid, input pi_value, input tau_value, input order_number,
                   input last_order, output ready);
endinterface

interface mieafr_csr_if import mieafr_pkg::*; ();
   logic          valid;
   logic          ready;
   order_num_type order_count;

   modport source (output valid, output order_count, input ready);
   modport sink   (input valid, input order_count, output ready);
endinterface

@@ sv/mieafr_ctrl.sv @@
// Sequencer: order count register, run bookkeeping and step commands to the datapath.
module mieafr_ctrl import mieafr_pkg::*; #(
   parameter int MAX_ORDERS = MAX_ORDERS_DEFAULT,
   parameter int ORDER_W    = $clog2(MAX_ORDERS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  order_num_type       csr_order_count,
   output logic                csr_ready,
   input  logic                req_valid,
   output logic                req_ready,
   input  dp_status_type       status,
   output dp_cmd_type          cmd,
   output logic [ORDER_W-1:0]  order
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_SQUARE = 14'b00000000000010,
      ST_EMIT   = 14'b00000000000100,
      ST_MULA   = 14'b00000000001000,
      ST_RNDA   = 14'b00000000010000,
      ST_SCALEA = 14'b00000000100000,
      ST_NUMER  = 14'b00000001000000,
      ST_DIVLO  = 14'b00000010000000,
      ST_DIVHI  = 14'b00000100000000,
      ST_QSAT   = 14'b00001000000000,
      ST_MULB   = 14'b00010000000000,
      ST_RNDB   = 14'b00100000000000,
      ST_SCALEB = 14'b01000000000000,
      ST_TAU    = 14'b10000000000000
   } state_type;

   state_type           state_ff, state_in;
   order_num_type       order_count_ff, order_count_in;
   logic [ORDER_W-1:0]  count_ff, count_in;
   logic [ORDER_W-1:0]  order_ff, order_in;
   logic [ORDER_W-1:0]  count_sel;
   logic                is_last;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign order     = order_ff;
   assign is_last   = (order_ff == count_ff);

   always_comb begin
      priority if (order_count_ff < ORDER_COUNT_MIN) begin
         count_sel = ORDER_W'(ORDER_COUNT_MIN);
      end else if (32'(order_count_ff) > MAX_ORDERS) begin
         count_sel = ORDER_W'(MAX_ORDERS);
      end else begin
         count_sel = ORDER_W'(order_count_ff);
      end
   end

   always_comb begin
      order_count_in = order_count_ff;
      if (csr_valid) begin
         order_count_in = csr_order_count;
      end
   end

   always_comb begin
      state_in = state_ff;
      order_in = order_ff;
      count_in = count_ff;
      cmd      = '0;
      cmd.last = is_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               order_in = ORDER_W'(1);
               count_in = count_sel;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  order_in = order_ff + ORDER_W'(1);
                  state_in = (order_ff == ORDER_W'(1)) ? ST_EMIT : ST_MULA;
               end
            end
         end
         ST_MULA: begin
            cmd.mul_a = 1'b1;
            state_in  = ST_RNDA;
         end
         ST_RNDA: begin
            cmd.round = 1'b1;
            state_in  = ST_SCALEA;
         end
         ST_SCALEA: begin
            cmd.scale_a = 1'b1;
            state_in    = ST_NUMER;
         end
         ST_NUMER: begin
            cmd.numer = 1'b1;
            state_in  = ST_DIVLO;
         end
         ST_DIVLO: begin
            cmd.div_lo = 1'b1;
            state_in   = ST_DIVHI;
         end
         ST_DIVHI: begin
            cmd.div_hi = 1'b1;
            state_in   = ST_QSAT;
         end
         ST_QSAT: begin
            cmd.quo_sat = 1'b1;
            state_in    = ST_MULB;
         end
         ST_MULB: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_RNDB;
         end
         ST_RNDB: begin
            cmd.round = 1'b1;
            state_in  = ST_SCALEB;
         end
         ST_SCALEB: begin
            cmd.scale_b = 1'b1;
            state_in    = ST_TAU;
         end
         ST_TAU: begin
            cmd.tau  = 1'b1;
            state_in = ST_EMIT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         order_count_ff <= ORDER_COUNT_RESET;
         count_ff       <= '0;
         order_ff       <= '0;
      end else begin
         state_ff       <= state_in;
         order_count_ff <= order_count_in;
         count_ff       <= count_in;
         order_ff       <= order_in;
      end
   end

endmodule

@@ sv/mieafr_dp.sv @@
// Datapath: recurrence registers, shared multipliers, reciprocal table and result register.
module mieafr_dp import mieafr_pkg::*; #(
   parameter int MAX_ORDERS = MAX_ORDERS_DEFAULT,
   parameter int ORDER_W    = $clog2(MAX_ORDERS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [ORDER_W-1:0]  order,
   input  cos_type             cos_angle,
   output dp_status_type       status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output result_type          pi_value,
   output result_type          tau_value,
   output order_num_type       order_number,
   output logic                last_order
);

   localparam int RI_W     = $clog2(MAX_ORDERS);
   localparam int RT_DEPTH = 2 ** RI_W;
   localparam int PROD_W   = RESULT_W + COS_W;
   localparam int SQ_W     = 2 * COS_W;
   localparam int TAU2_W   = SQ_W + 4;
   localparam int CO_W     = ORDER_W + 2;
   localparam int MULT_W   = RESULT_W + CO_W;
   localparam int NUM_W    = MULT_W + 1;
   localparam int HI_W     = NUM_W - RECIP_W;
   localparam int LOP_W    = 2 * RECIP_W;
   localparam int QUO_W    = HI_W + RECIP_W + 2;
   localparam int ROUND_Q  = 2 ** (FRAC_W - 1);

   localparam logic [LOP_W:0] DIV_HALF = (LOP_W + 1)'(1) << (RECIP_W - 1);

   logic [RECIP_W-1:0]        recip_table [RT_DEPTH];

   cos_type                   mu_ff;
   logic signed [SQ_W-1:0]    musq_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   result_type                rnd_ff;
   logic signed [MULT_W-1:0]  t_ff;
   logic signed [NUM_W-1:0]   num_ff;
   logic [LOP_W-1:0]          lo_prod_ff;
   logic signed [QUO_W-1:0]   quo_ff;
   result_type                pn_ff;
   result_type                tau_ff;
   result_type                pi_prev_ff;
   result_type                pi_bp_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   result_type                pi_out_ff;
   result_type                tau_out_ff;
   order_num_type             order_out_ff;
   logic                      last_out_ff;

   logic [ORDER_W-1:0]        div_order;
   logic [RECIP_W-1:0]        recip;
   logic signed [CO_W-1:0]    coef_a;
   logic signed [CO_W-1:0]    coef_n;
   logic signed [CO_W-1:0]    coef_n1;
   logic signed [PROD_W:0]    prod_rnd;
   logic [LOP_W:0]            low_sum;
   logic signed [TAU2_W-1:0]  tau2_core;
   logic signed [TAU2_W-1:0]  tau2_wide;
   result_type                pi2;
   result_type                tau2;
   result_type                pi_emit;
   result_type                tau_emit;

   genvar gi;
   generate
      for (gi = 0; gi < RT_DEPTH; gi++) begin : g_recip
         if (gi >= 2) begin : g_entry
            localparam longint unsigned RECIP_FULL = ((64'd1 << RECIP_W) + gi / 2) / gi;
            assign recip_table[gi] = RECIP_FULL[RECIP_W-1:0];
         end else begin : g_unused
            assign recip_table[gi] = '0;
         end
      end
   endgenerate

   assign div_order = order - ORDER_W'(1);
   assign recip     = recip_table[div_order[RI_W-1:0]];

   assign coef_a  = $signed({1'b0, (ORDER_W + 1)'({order, 1'b0} - (ORDER_W + 1)'(1))});
   assign coef_n  = $signed({2'b00, order});
   assign coef_n1 = $signed({1'b0, (ORDER_W + 1)'(order) + (ORDER_W + 1)'(1)});

   assign prod_rnd = $signed({prod_ff[PROD_W-1], prod_ff}) + (PROD_W + 1)'(ROUND_Q);
   assign low_sum  = {1'b0, lo_prod_ff} + DIV_HALF;

   assign tau2_core = (TAU2_W'(musq_ff) <<< 1) - (TAU2_W'(1) <<< (2 * FRAC_W));
   assign tau2_wide = (tau2_core <<< 1) + tau2_core + TAU2_W'(ROUND_Q);
   assign tau2      = RESULT_W'(tau2_wide >>> FRAC_W);
   assign pi2       = (RESULT_W'(mu_ff) <<< 1) + RESULT_W'(mu_ff);

   always_comb begin
      priority if (order == ORDER_W'(1)) begin
         pi_emit  = ONE_Q16;
         tau_emit = RESULT_W'(mu_ff);
      end else if (order == ORDER_W'(2)) begin
         pi_emit  = pi2;
         tau_emit = tau2;
      end else begin
         pi_emit  = pn_ff;
         tau_emit = tau_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mu_ff <= cos_angle;
      end
      if (cmd.square) begin
         musq_ff <= SQ_W'(mu_ff) * SQ_W'(mu_ff);
      end
      if (cmd.mul_a) begin
         prod_ff <= PROD_W'(pi_prev_ff) * PROD_W'(mu_ff);
      end else if (cmd.mul_b) begin
         prod_ff <= PROD_W'(pn_ff) * PROD_W'(mu_ff);
      end
      if (cmd.round) begin
         rnd_ff <= sat_result(SAT_IN_W'($signed(prod_rnd[PROD_W:FRAC_W])));
      end
      if (cmd.scale_a) begin
         t_ff <= MULT_W'(coef_a) * MULT_W'(rnd_ff);
      end else if (cmd.scale_b) begin
         t_ff <= MULT_W'(coef_n) * MULT_W'(rnd_ff);
      end
      if (cmd.numer) begin
         num_ff <= NUM_W'(t_ff) - NUM_W'(MULT_W'(coef_n) * MULT_W'(pi_bp_ff));
      end
      if (cmd.div_lo) begin
         lo_prod_ff <= LOP_W'(num_ff[RECIP_W-1:0]) * LOP_W'(recip);
      end
      if (cmd.div_hi) begin
         quo_ff <= QUO_W'($signed(num_ff[NUM_W-1:RECIP_W])) * QUO_W'($signed({1'b0, recip}))
                   + QUO_W'($signed({1'b0, low_sum[LOP_W:RECIP_W]}));
      end
      if (cmd.quo_sat) begin
         pn_ff <= sat_result(SAT_IN_W'(quo_ff));
      end
      if (cmd.tau) begin
         tau_ff <= sat_result(SAT_IN_W'(t_ff)
                              - SAT_IN_W'(MULT_W'(coef_n1) * MULT_W'(pi_prev_ff)));
      end
      if (cmd.emit) begin
         pi_out_ff    <= pi_emit;
         tau_out_ff   <= tau_emit;
         order_out_ff <= ORDER_NUM_W'(order);
         last_out_ff  <= cmd.last;
         if (order == ORDER_W'(2)) begin
            pi_bp_ff   <= ONE_Q16;
            pi_prev_ff <= pi2;
         end else if (order != ORDER_W'(1)) begin
            pi_bp_ff   <= pi_prev_ff;
            pi_prev_ff <= pn_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign pi_value        = pi_out_ff;
   assign tau_value       = tau_out_ff;
   assign order_number    = order_out_ff;
   assign last_order      = last_out_ff;

endmodule

@@ sv/mie_angular_function_recurrence_core.sv @@
// Top level of the Mie angular function core: channels, sequencer and datapath.
//
// Each cosine transfer starts a run that returns one result per order, from order one up
// to the order count register (raised to two, lowered to MAX_ORDERS). Orders one and two
// take a setup step that squares the cosine and then one result load each; every later
// order steps through the sequencer states (product with the cosine, rounding, scaling,
// numerator, two reciprocal multiply steps, saturation, tau product, rounding, scaling,
// tau, result load), and a result load waits while the result side stalls. The result
// register decouples the two sides: a new cosine is taken in the cycle after the last
// result of a run is loaded.
// Write the order count only while no run is in progress.
module mie_angular_function_recurrence_core import mieafr_pkg::*; #(
   parameter int MAX_ORDERS = MAX_ORDERS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   mieafr_req_if.sink    req_ch,
   mieafr_rsp_if.source  rsp_ch,
   mieafr_csr_if.sink    csr_ch
);

   localparam int ORDER_W = $clog2(MAX_ORDERS + 1);

   dp_cmd_type          cmd;
   dp_status_type       status;
   logic [ORDER_W-1:0]  order;

   mieafr_ctrl #(
      .MAX_ORDERS (MAX_ORDERS),
      .ORDER_W    (ORDER_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_ch.valid),
      .csr_order_count (csr_ch.order_count),
      .csr_ready       (csr_ch.ready),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .status          (status),
      .cmd             (cmd),
      .order           (order)
   );

   mieafr_dp #(
      .MAX_ORDERS (MAX_ORDERS),
      .ORDER_W    (ORDER_W)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .order        (order),
      .cos_angle    (req_ch.cos_angle),
      .status       (status),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .pi_value     (rsp_ch.pi_value),
      .tau_value    (rsp_ch.tau_value),
      .order_number (rsp_ch.order_number),
      .last_order   (rsp_ch.last_order)
   );

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for the Mie angular function core: directed table, then random cosines.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mieafr_pkg::*;

   localparam int ORDER_LIMIT    = MAX_ORDERS_DEFAULT;
   localparam int ROW_COUNT      = 19;
   localparam int RANDOM_ITEMS   = 250;
   localparam int IDLE_PAUSE     = 24;
   localparam int TAIL_CYCLES    = 64;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      result_type    pi;
      result_type    tau;
      order_num_type order;
      logic          last;
   } angular_result_type;

   typedef struct {
      bit            set_count;
      order_num_type count;
      cos_type       cos;
      bit            typed;
      result_type    pi2;
      result_type    tau2;
   } angle_row_type;

   logic clock;
   logic reset;

   mieafr_req_if req_bus ();
   mieafr_rsp_if rsp_bus ();
   mieafr_csr_if csr_bus ();

   mie_angular_function_recurrence_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   order_num_type      order_count_copy;
   longint             pi_last;
   longint             pi_older;
   order_num_type      order_done;
   cos_type            held_cosine;
   angular_result_type pending_orders[$];
   int                 mismatch_count;
   int                 quiet_cycles;
   bit                 no_gaps;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint clamp48(input longint x);
      if (x > longint'(RESULT_MAX)) return longint'(RESULT_MAX);
      if (x < longint'(RESULT_MIN)) return longint'(RESULT_MIN);
      return x;
   endfunction

   function automatic longint cos_product(input longint a, input longint mu);
      longint hi;
      longint lo;
      hi = a >>> FRAC_W;
      lo = a - (hi <<< FRAC_W);
      return clamp48(hi * mu + ((lo * mu + 32768) >>> FRAC_W));
   endfunction

   function automatic longint order_quotient(input longint num, input longint unsigned d);
      longint unsigned recip;
      longint unsigned lo;
      longint unsigned low;
      longint          hi;
      recip = ((64'd1 << RECIP_W) + d / 2) / d;
      hi    = num >>> RECIP_W;
      lo    = $unsigned(num - (hi <<< RECIP_W));
      low   = (lo * recip + (64'd1 << (RECIP_W - 1))) >> RECIP_W;
      return clamp48(hi * $signed(recip) + $signed(low));
   endfunction

   function automatic int predict_angular_orders(input cos_type c);
      int                 count;
      int                 n;
      longint             mu;
      longint             p2;
      longint             t;
      longint             num;
      longint             pn;
      longint             tn;
      angular_result_type r;
      count = order_count_copy;
      if (count < 2) count = 2;
      if (count > ORDER_LIMIT) count = ORDER_LIMIT;
      held_cosine = c;
      mu = c;
      r.pi    = ONE_Q16;
      r.tau   = result_type'(mu);
      r.order = order_num_type'(1);
      r.last  = 1'b0;
      pending_orders.insert(pending_orders.size(), r);
      p2 = 3 * mu;
      t  = (3 * (2 * mu * mu - (longint'(1) <<< 32)) + 32768) >>> FRAC_W;
      r.pi    = result_type'(p2);
      r.tau   = result_type'(t);
      r.order = order_num_type'(2);
      r.last  = (count == 2);
      pending_orders.insert(pending_orders.size(), r);
      pi_older   = ONE_Q16;
      pi_last    = p2;
      order_done = order_num_type'(2);
      for (n = 3; n <= count; n++) begin
         num = (2 * n - 1) * cos_product(pi_last, mu) - n * pi_older;
         pn  = order_quotient(num, n - 1);
         tn  = clamp48(n * cos_product(pn, mu) - (n + 1) * pi_last);
         r.pi    = result_type'(pn);
         r.tau   = result_type'(tn);
         r.order = order_num_type'(n);
         r.last  = (n == count);
         pending_orders.insert(pending_orders.size(), r);
         pi_older   = pi_last;
         pi_last    = pn;
         order_done = order_num_type'(n);
      end
      return count;
   endfunction

   function automatic int idle_length();
      int pick;
      if (no_gaps) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic cos_type random_cosine();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return cos_type'(int'($urandom_range(0, 131072)) - 65536);
      if (pick < 85) return cos_type'($urandom);
      return cos_type'(((pick % 2) ? 65536 : -65536) + int'($urandom_range(0, 8)) - 4);
   endfunction

   function automatic order_num_type random_order_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return order_num_type'($urandom_range(2, 10));
      if (pick < 80) return order_num_type'($urandom_range(11, 30));
      if (pick < 90) begin
         if ($urandom_range(0, 1) == 0) return order_num_type'($urandom_range(0, 1));
         return order_num_type'($urandom_range(65, 127));
      end
      return order_num_type'($urandom_range(31, 64));
   endfunction

   task automatic send_cosine(input cos_type c, input bit typed, input result_type pi2,
                              input result_type tau2);
      int gap;
      int count;
      gap = idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cos_angle <= c;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      count = predict_angular_orders(c);
      if (typed) begin
         pending_orders[pending_orders.size() - count + 1].pi  = pi2;
         pending_orders[pending_orders.size() - count + 1].tau = tau2;
      end
      @(negedge clock);
   endtask

   task automatic write_order_count(input order_num_type v);
      req_bus.valid <= 1'b0;
      while (pending_orders.size() != 0) @(negedge clock);
      repeat (IDLE_PAUSE) @(negedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.order_count <= v;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      order_count_copy = v;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // hold ready low for a random stall after each ready cycle
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      angular_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_orders.size() == 0) begin
            $error("unexpected result transfer, order_number %0d", rsp_bus.order_number);
            mismatch_count++;
         end else begin
            want = pending_orders.pop_front();
            if (rsp_bus.pi_value !== want.pi) begin
               $error("pi_value: expected %0d, got %0d", want.pi, rsp_bus.pi_value);
               mismatch_count++;
            end
            if (rsp_bus.tau_value !== want.tau) begin
               $error("tau_value: expected %0d, got %0d", want.tau, rsp_bus.tau_value);
               mismatch_count++;
            end
            if (rsp_bus.order_number !== want.order) begin
               $error("order_number: expected %0d, got %0d", want.order,
                      rsp_bus.order_number);
               mismatch_count++;
            end
            if (rsp_bus.last_order !== want.last) begin
               $error("last_order: expected %0d, got %0d", want.last, rsp_bus.last_order);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      angle_row_type rows [ROW_COUNT];
      int            sent;
      int            phase_items;
      order_num_type count_pick;
      rows = '{
         '{1'b0, 7'd0,   18'sd0,      1'b1, 48'sd0,       -48'sd196608},
         '{1'b1, 7'd2,   18'sd65536,  1'b1, 48'sd196608,  48'sd196608},
         '{1'b0, 7'd0,   -18'sd65536, 1'b1, -48'sd196608, 48'sd196608},
         '{1'b1, 7'd0,   18'sd131071, 1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   18'sh20000,  1'b0, 48'sd0,       48'sd0},
         '{1'b1, 7'd1,   18'sd0,      1'b1, 48'sd0,       -48'sd196608},
         '{1'b1, 7'd3,   18'sd32768,  1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   -18'sd32768, 1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   18'sd1,      1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   -18'sd1,     1'b0, 48'sd0,       48'sd0},
         '{1'b1, 7'd127, 18'sd131071, 1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   18'sh20000,  1'b0, 48'sd0,       48'sd0},
         '{1'b1, 7'd65,  18'sd46341,  1'b0, 48'sd0,       48'sd0},
         '{1'b1, 7'd64,  18'sd65536,  1'b1, 48'sd196608,  48'sd196608},
         '{1'b0, 7'd0,   -18'sd65536, 1'b1, -48'sd196608, 48'sd196608},
         '{1'b1, 7'd5,   18'sd98304,  1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   -18'sd98304, 1'b0, 48'sd0,       48'sd0},
         '{1'b1, 7'd20,  18'sd131071, 1'b0, 48'sd0,       48'sd0},
         '{1'b0, 7'd0,   18'sd12345,  1'b0, 48'sd0,       48'sd0}
      };
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.cos_angle   = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.order_count = '0;
      no_gaps             = 1'b0;
      mismatch_count      = 0;
      quiet_cycles        = 0;
      order_count_copy    = ORDER_COUNT_RESET;
      pi_last             = 0;
      pi_older            = 0;
      order_done          = '0;
      held_cosine         = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (rows[i].set_count) write_order_count(rows[i].count);
         send_cosine(rows[i].cos, rows[i].typed, rows[i].pi2, rows[i].tau2);
      end

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         count_pick = random_order_count();
         write_order_count(count_pick);
         no_gaps     = ($urandom_range(0, 3) == 0);
         phase_items = $urandom_range(3, 12);
         repeat (phase_items) begin
            send_cosine(random_cosine(), 1'b0, '0, '0);
            sent++;
         end
      end

      // drain the last run before the final verdict
      req_bus.valid <= 1'b0;
      while (pending_orders.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/mieafr_pkg.sv
sv/mieafr_if.sv
sv/mieafr_ctrl.sv
sv/mieafr_dp.sv
sv/mie_angular_function_recurrence_core.sv
bench/tb_top.sv
